[hw/rtl/gradient_noise_3d_macros.svh]
// Assertion helpers for the gradient noise block.
`ifndef GRADIENT_NOISE_3D_MACROS_SVH
`define GRADIENT_NOISE_3D_MACROS_SVH

`define GNZ_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

`define GNZ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hw/rtl/gnz_pkg.sv]
package gnz_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int INT_BITS    = 8;
  localparam int COORD_W     = INT_BITS + FRAC_BITS;
  localparam int OUT_W       = FRAC_BITS + 2;
  localparam int MW          = FRAC_BITS + 6;
  localparam int PW          = 2 * MW;
  localparam int N_CORNERS   = 8;
  localparam int FIFO_DEPTH  = 16;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = FIFO_AW + 1;

  typedef logic signed [MW-1:0] fx_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef fx_t grad_arr_t [N_CORNERS];

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_e;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  localparam fx_t ONE_FX     = fx_t'(1 << FRAC_BITS);
  localparam fx_t TEN_FX     = fx_t'(10 << FRAC_BITS);
  localparam fx_t FIFTEEN_FX = fx_t'(15 << FRAC_BITS);
  localparam fx_t OUT_MAX    = fx_t'((1 << (FRAC_BITS + 1)) - 1);
  localparam fx_t OUT_MIN    = fx_t'(-(1 << (FRAC_BITS + 1)));
  localparam logic signed [PW-1:0] HALF_P = PW'(1 << (FRAC_BITS - 1));

  function automatic fx_t frac_to_fx(input frac_t f);
    return fx_t'({{(MW - FRAC_BITS){1'b0}}, f});
  endfunction

  // product scaled back by FRAC_BITS, rounded half up
  function automatic fx_t mul_round(input fx_t a, input fx_t b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b) + HALF_P;
    return fx_t'(p[FRAC_BITS +: MW]);
  endfunction

  function automatic fx_t lerp(input fx_t t, input fx_t a, input fx_t b);
    return a + mul_round(t, b - a);
  endfunction

  function automatic fx_t grad(input logic [3:0] h, input fx_t x, input fx_t y, input fx_t z);
    fx_t u;
    fx_t v;
    u = (h < 4'd8) ? x : y;
    v = (h < 4'd4) ? y : (((h == 4'd12) || (h == 4'd14)) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

endpackage

[hw/rtl/gnz_perm_ram.sv]
module gnz_perm_ram (
  input  logic              clk_i,
  input  logic              we_i,
  input  gnz_pkg::idx_t     waddr_i,
  input  gnz_pkg::idx_t     wdata_i,
  input  gnz_pkg::idx_t     raddr_a_i,
  input  gnz_pkg::idx_t     raddr_b_i,
  output gnz_pkg::idx_t     rdata_a_o,
  output gnz_pkg::idx_t     rdata_b_o
);

  gnz_pkg::idx_t mem_q [gnz_pkg::TABLE_DEPTH];
  gnz_pkg::idx_t rdata_a_q;
  gnz_pkg::idx_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[hw/rtl/gnz_fade.sv]
module gnz_fade (
  input  logic                 clk_i,
  input  gnz_pkg::frac_t       t_i,
  output gnz_pkg::fx_t         fade_o
);

  gnz_pkg::fx_t t_q [4];
  gnz_pkg::fx_t f_q [4];
  gnz_pkg::fx_t fade_q;
  gnz_pkg::fx_t t_ext;

  assign t_ext = gnz_pkg::frac_to_fx(t_i);

  // Horner: ((6t-15)t+10)t*t*t
  always_ff @(posedge clk_i) begin
    t_q[0] <= t_ext;
    f_q[0] <= (t_ext <<< 2) + (t_ext <<< 1) - gnz_pkg::FIFTEEN_FX;
    t_q[1] <= t_q[0];
    f_q[1] <= gnz_pkg::mul_round(t_q[0], f_q[0]) + gnz_pkg::TEN_FX;
    t_q[2] <= t_q[1];
    f_q[2] <= gnz_pkg::mul_round(t_q[1], f_q[1]);
    t_q[3] <= t_q[2];
    f_q[3] <= gnz_pkg::mul_round(t_q[2], f_q[2]);
    fade_q <= gnz_pkg::mul_round(t_q[3], f_q[3]);
  end

  assign fade_o = fade_q;

endmodule

[hw/rtl/gnz_hash.sv]
module gnz_hash (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  gnz_pkg::cmd_e                 cmd_i,
  input  logic [gnz_pkg::COORD_W-1:0]   x_coord_i,
  input  logic [gnz_pkg::COORD_W-1:0]   y_coord_i,
  input  logic [gnz_pkg::COORD_W-1:0]   z_coord_i,
  input  gnz_pkg::idx_t                 entry_index_i,
  input  gnz_pkg::idx_t                 entry_value_i,
  output logic                          valid_o,
  output gnz_pkg::grad_arr_t            grad_o
);

  localparam int FB = gnz_pkg::FRAC_BITS;

  logic          v1_q, v2_q, v3_q, v4_q;
  logic          ld1_q, ld2_q;
  gnz_pkg::idx_t widx1_q, widx2_q, wval1_q, wval2_q;
  gnz_pkg::idx_t yi1_q, zi1_q, zi2_q;
  gnz_pkg::frac_t xf_q [3];
  gnz_pkg::frac_t yf_q [3];
  gnz_pkg::frac_t zf_q [3];
  gnz_pkg::grad_arr_t grad_q;

  gnz_pkg::idx_t xi, p_x0, p_x1, a, b;
  gnz_pkg::idx_t p_a0, p_a1, p_b0, p_b1, aa, ab, ba, bb;
  gnz_pkg::idx_t h_aa0, h_aa1, h_ab0, h_ab1, h_ba0, h_ba1, h_bb0, h_bb1;
  logic          ld0;
  gnz_pkg::fx_t  x0, y0, z0, x1, y1, z1;

  assign xi  = x_coord_i[FB +: gnz_pkg::IDX_W];
  assign ld0 = valid_i && (cmd_i == gnz_pkg::CMD_LOAD);

  // each table copy is written as a load passes the stage that reads it
  gnz_perm_ram u_ram_x (
    .clk_i, .we_i(ld0), .waddr_i(entry_index_i), .wdata_i(entry_value_i),
    .raddr_a_i(xi), .raddr_b_i(xi + gnz_pkg::idx_t'(1)),
    .rdata_a_o(p_x0), .rdata_b_o(p_x1)
  );

  assign a = p_x0 + yi1_q;
  assign b = p_x1 + yi1_q;

  gnz_perm_ram u_ram_a (
    .clk_i, .we_i(ld1_q), .waddr_i(widx1_q), .wdata_i(wval1_q),
    .raddr_a_i(a), .raddr_b_i(a + gnz_pkg::idx_t'(1)),
    .rdata_a_o(p_a0), .rdata_b_o(p_a1)
  );

  gnz_perm_ram u_ram_b (
    .clk_i, .we_i(ld1_q), .waddr_i(widx1_q), .wdata_i(wval1_q),
    .raddr_a_i(b), .raddr_b_i(b + gnz_pkg::idx_t'(1)),
    .rdata_a_o(p_b0), .rdata_b_o(p_b1)
  );

  assign aa = p_a0 + zi2_q;
  assign ab = p_a1 + zi2_q;
  assign ba = p_b0 + zi2_q;
  assign bb = p_b1 + zi2_q;

  gnz_perm_ram u_ram_aa (
    .clk_i, .we_i(ld2_q), .waddr_i(widx2_q), .wdata_i(wval2_q),
    .raddr_a_i(aa), .raddr_b_i(aa + gnz_pkg::idx_t'(1)),
    .rdata_a_o(h_aa0), .rdata_b_o(h_aa1)
  );

  gnz_perm_ram u_ram_ab (
    .clk_i, .we_i(ld2_q), .waddr_i(widx2_q), .wdata_i(wval2_q),
    .raddr_a_i(ab), .raddr_b_i(ab + gnz_pkg::idx_t'(1)),
    .rdata_a_o(h_ab0), .rdata_b_o(h_ab1)
  );

  gnz_perm_ram u_ram_ba (
    .clk_i, .we_i(ld2_q), .waddr_i(widx2_q), .wdata_i(wval2_q),
    .raddr_a_i(ba), .raddr_b_i(ba + gnz_pkg::idx_t'(1)),
    .rdata_a_o(h_ba0), .rdata_b_o(h_ba1)
  );

  gnz_perm_ram u_ram_bb (
    .clk_i, .we_i(ld2_q), .waddr_i(widx2_q), .wdata_i(wval2_q),
    .raddr_a_i(bb), .raddr_b_i(bb + gnz_pkg::idx_t'(1)),
    .rdata_a_o(h_bb0), .rdata_b_o(h_bb1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      ld1_q <= 1'b0;
      ld2_q <= 1'b0;
    end else begin
      v1_q  <= valid_i && (cmd_i == gnz_pkg::CMD_EVAL);
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      ld1_q <= ld0;
      ld2_q <= ld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    widx1_q <= entry_index_i;
    wval1_q <= entry_value_i;
    widx2_q <= widx1_q;
    wval2_q <= wval1_q;
    yi1_q   <= y_coord_i[FB +: gnz_pkg::IDX_W];
    zi1_q   <= z_coord_i[FB +: gnz_pkg::IDX_W];
    zi2_q   <= zi1_q;
    xf_q[0] <= x_coord_i[FB-1:0];
    yf_q[0] <= y_coord_i[FB-1:0];
    zf_q[0] <= z_coord_i[FB-1:0];
    xf_q[1] <= xf_q[0];
    yf_q[1] <= yf_q[0];
    zf_q[1] <= zf_q[0];
    xf_q[2] <= xf_q[1];
    yf_q[2] <= yf_q[1];
    zf_q[2] <= zf_q[1];
  end

  assign x0 = gnz_pkg::frac_to_fx(xf_q[2]);
  assign y0 = gnz_pkg::frac_to_fx(yf_q[2]);
  assign z0 = gnz_pkg::frac_to_fx(zf_q[2]);
  assign x1 = x0 - gnz_pkg::ONE_FX;
  assign y1 = y0 - gnz_pkg::ONE_FX;
  assign z1 = z0 - gnz_pkg::ONE_FX;

  always_ff @(posedge clk_i) begin
    grad_q[0] <= gnz_pkg::grad(h_aa0[3:0], x0, y0, z0);
    grad_q[1] <= gnz_pkg::grad(h_ba0[3:0], x1, y0, z0);
    grad_q[2] <= gnz_pkg::grad(h_ab0[3:0], x0, y1, z0);
    grad_q[3] <= gnz_pkg::grad(h_bb0[3:0], x1, y1, z0);
    grad_q[4] <= gnz_pkg::grad(h_aa1[3:0], x0, y0, z1);
    grad_q[5] <= gnz_pkg::grad(h_ba1[3:0], x1, y0, z1);
    grad_q[6] <= gnz_pkg::grad(h_ab1[3:0], x0, y1, z1);
    grad_q[7] <= gnz_pkg::grad(h_bb1[3:0], x1, y1, z1);
  end

  assign valid_o = v4_q;
  assign grad_o  = grad_q;

endmodule

[hw/rtl/gnz_blend.sv]
module gnz_blend (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  gnz_pkg::grad_arr_t          grad_i,
  input  gnz_pkg::fx_t                u_i,
  input  gnz_pkg::fx_t                v_i,
  input  gnz_pkg::fx_t                w_i,
  output logic                        valid_o,
  output logic [gnz_pkg::OUT_W-1:0]   noise_o
);

  logic va_q, vb_q, vc_q, vd_q;
  gnz_pkg::grad_arr_t g_q;
  gnz_pkg::fx_t l_q [4];
  gnz_pkg::fx_t m_q [2];
  gnz_pkg::fx_t v_q, w1_q, w2_q;
  gnz_pkg::fx_t r;
  gnz_pkg::fx_t r_sat;
  logic [gnz_pkg::OUT_W-1:0] noise_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  assign r = gnz_pkg::lerp(w2_q, m_q[0], m_q[1]);

  always_comb begin
    r_sat = r;
    if (r > gnz_pkg::OUT_MAX) begin
      r_sat = gnz_pkg::OUT_MAX;
    end else if (r < gnz_pkg::OUT_MIN) begin
      r_sat = gnz_pkg::OUT_MIN;
    end
  end

  always_ff @(posedge clk_i) begin
    g_q     <= grad_i;
    l_q[0]  <= gnz_pkg::lerp(u_i, g_q[0], g_q[1]);
    l_q[1]  <= gnz_pkg::lerp(u_i, g_q[2], g_q[3]);
    l_q[2]  <= gnz_pkg::lerp(u_i, g_q[4], g_q[5]);
    l_q[3]  <= gnz_pkg::lerp(u_i, g_q[6], g_q[7]);
    v_q     <= v_i;
    w1_q    <= w_i;
    m_q[0]  <= gnz_pkg::lerp(v_q, l_q[0], l_q[1]);
    m_q[1]  <= gnz_pkg::lerp(v_q, l_q[2], l_q[3]);
    w2_q    <= w1_q;
    noise_q <= r_sat[gnz_pkg::OUT_W-1:0];
  end

  assign valid_o = vd_q;
  assign noise_o = noise_q;

endmodule

[hw/rtl/gnz_out_fifo.sv]
module gnz_out_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [gnz_pkg::OUT_W-1:0]   data_i,
  input  logic                        pop_i,
  output logic [gnz_pkg::OUT_W-1:0]   data_o,
  output gnz_pkg::fifo_status_t       status_o
);

  logic [gnz_pkg::OUT_W-1:0] mem_q [gnz_pkg::FIFO_DEPTH];
  logic [gnz_pkg::FIFO_AW-1:0] wr_q, rd_q;
  logic [gnz_pkg::CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + gnz_pkg::CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - gnz_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + gnz_pkg::FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + gnz_pkg::FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o         = mem_q[rd_q];
  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == gnz_pkg::CNT_W'(gnz_pkg::FIFO_DEPTH));

endmodule

[hw/rtl/gradient_noise_3d.sv]
// An accepted evaluate passes the hash, fade and blend pipelines and the result FIFO
// before valid_o rises. Throughput: one transaction per cycle while stall_o is low,
// set by seven dual-read-port table copies, one, two and four on the three hash levels.
// Reset clears all control state; the table is undefined until loaded
// and gets no clearing pass. Load transactions produce no output.
`include "gradient_noise_3d_macros.svh"

module gradient_noise_3d (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic                          cmd_i,
  input  logic [gnz_pkg::COORD_W-1:0]   x_coord_i,
  input  logic [gnz_pkg::COORD_W-1:0]   y_coord_i,
  input  logic [gnz_pkg::COORD_W-1:0]   z_coord_i,
  input  logic [gnz_pkg::IDX_W-1:0]     entry_index_i,
  input  logic [gnz_pkg::IDX_W-1:0]     entry_value_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [gnz_pkg::OUT_W-1:0]     noise_value_o
);

  localparam int FB = gnz_pkg::FRAC_BITS;

  logic                      accept, eval_in, pop;
  logic                      hash_valid, blend_valid;
  gnz_pkg::cmd_e             cmd;
  gnz_pkg::grad_arr_t        grads;
  gnz_pkg::fx_t              fade_u, fade_v, fade_w;
  logic [gnz_pkg::OUT_W-1:0] blend_noise;
  gnz_pkg::fifo_status_t     fifo_status;
  logic [gnz_pkg::CNT_W-1:0] cnt_q, cnt_d;

  assign cmd     = gnz_pkg::cmd_e'(cmd_i);
  assign accept  = valid_i && !stall_o;
  assign eval_in = accept && (cmd == gnz_pkg::CMD_EVAL);
  assign pop     = valid_o && !stall_i;

  // credits: evaluates in flight plus results queued
  assign stall_o = (cnt_q == gnz_pkg::CNT_W'(gnz_pkg::FIFO_DEPTH));

  always_comb begin
    cnt_d = cnt_q;
    if (eval_in && !pop) begin
      cnt_d = cnt_q + gnz_pkg::CNT_W'(1);
    end else if (pop && !eval_in) begin
      cnt_d = cnt_q - gnz_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  gnz_hash u_hash (
    .clk_i,
    .rst_ni,
    .valid_i       (accept),
    .cmd_i         (cmd),
    .x_coord_i,
    .y_coord_i,
    .z_coord_i,
    .entry_index_i,
    .entry_value_i,
    .valid_o       (hash_valid),
    .grad_o        (grads)
  );

  gnz_fade u_fade_x (.clk_i, .t_i(x_coord_i[FB-1:0]), .fade_o(fade_u));
  gnz_fade u_fade_y (.clk_i, .t_i(y_coord_i[FB-1:0]), .fade_o(fade_v));
  gnz_fade u_fade_z (.clk_i, .t_i(z_coord_i[FB-1:0]), .fade_o(fade_w));

  gnz_blend u_blend (
    .clk_i,
    .rst_ni,
    .valid_i (hash_valid),
    .grad_i  (grads),
    .u_i     (fade_u),
    .v_i     (fade_v),
    .w_i     (fade_w),
    .valid_o (blend_valid),
    .noise_o (blend_noise)
  );

  gnz_out_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i   (blend_valid),
    .data_i   (blend_noise),
    .pop_i    (pop),
    .data_o   (noise_value_o),
    .status_o (fifo_status)
  );

  assign valid_o = !fifo_status.empty;

  `GNZ_ASSERT(a_credit_bound, cnt_q <= gnz_pkg::CNT_W'(gnz_pkg::FIFO_DEPTH), "credit overflow")
  `GNZ_ASSERT_IMP(a_push_room, blend_valid, !fifo_status.full, "result fifo overflow")
  `GNZ_ASSERT_IMP(a_out_credit, valid_o, cnt_q != '0, "output without credit")

endmodule
